// ===== hdl/prqs_pkg.sv =====
`default_nettype none
package prqs_pkg;

    typedef enum logic [3:0] {
        OP_ATTACH = 4'd0,
        OP_READY_ADD = 4'd1,
        OP_READY_REMOVE = 4'd2,
        OP_SELECT = 4'd3,
        OP_SWITCH = 4'd4,
        OP_BLOCK = 4'd5,
        OP_UNBLOCK = 4'd6,
        OP_WAKE_BEST = 4'd7,
        OP_FIND_BEST = 4'd8,
        OP_SET_PRIORITY = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_STATE = 2'd1,
        ST_ARG = 2'd2,
        ST_NONE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_BLOCKED = 2'd2
    } t_mode;

    localparam logic CFG_KERNEL_EN = 1'b0;
    localparam logic CFG_SCHED_START = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_LOADT,
        S_ADD0, S_ADD1, S_ADD2,
        S_REM0, S_REM1, S_REM2, S_REM3, S_REM4, S_REM5,
        S_UNBLK, S_BLK, S_PRIO, S_SEL1,
        S_SW1, S_SW2, S_SW3, S_SW4, S_SW5,
        S_SCAN, S_SCAN_END, S_WAKE,
        S_OUT, S_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/priority_ready_queue_scheduler.sv =====
`default_nettype none
// Priority ready-queue task scheduler. Each priority level keeps a FIFO ready list whose
// head and tail live in a level memory, while per-task links, priority, mode and wake code
// live in a task memory; bit vectors mark the ready, blocked and present tasks and the
// non-empty levels. One command item is taken at a time and answered with one result
// item. A ready add or a ready remove takes longer than a simple command or an error,
// since each link update is a read and a write-back through the task memory; unblock
// adds one more state to the insert. Wake-best and find-best scan the task memory one
// entry a cycle over every task, and wake-best then adds a list insert. A finished result,
// together with the schedule-pending flag it reports, sits in an output register, so the
// next command can be accepted while it waits to be taken.
module priority_ready_queue_scheduler #(
    parameter int TASK_COUNT = 32,
    parameter int LEVEL_COUNT = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_operation,
    input  wire logic [5:0]  i_task_id,
    input  wire logic [5:0]  i_priority_req,
    input  wire logic [2:0]  i_wake_code,
    input  wire logic [31:0] i_task_set,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [4:0]       o_chosen_task,
    output logic [4:0]       o_chosen_priority,
    output logic [2:0]       o_chosen_wake_code,
    output logic             o_schedule_pending,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_data
);
    import prqs_pkg::*;

    // Task ids carry one extra top bit; a set top bit means "no task".
    localparam int IX = $clog2(TASK_COUNT);
    localparam int IW = IX + 1;
    localparam int PW = $clog2(LEVEL_COUNT);
    localparam logic [IW-1:0] NIL = {1'b1, {IX{1'b0}}};

    typedef struct packed {
        logic [IW-1:0] nxt;
        logic [IW-1:0] prv;
        logic [PW-1:0] prio;
        t_mode mode;
        logic [2:0] wake;
    } t_task;

    typedef struct packed {
        logic [IW-1:0] head;
        logic [IW-1:0] tail;
    } t_lvl;

    function automatic logic [PW-1:0] first_one(input logic [LEVEL_COUNT-1:0] v);
        logic [PW-1:0] r;
        r = '0;
        for (int k = LEVEL_COUNT - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = PW'(k);
            end
        end
        return r;
    endfunction

    // Memories and their registered read data.
    t_task tm [TASK_COUNT];
    t_lvl lm [LEVEL_COUNT];
    t_task r_tq;
    t_lvl r_lq;
    logic r_lqv;
    logic [LEVEL_COUNT-1:0] r_lval;

    logic tm_we, lm_we;
    logic [IX-1:0] tm_wa, tm_ra;
    logic [PW-1:0] lm_wa, lm_ra;
    t_task tm_wd;
    t_lvl lm_wd;

    // Control and payload registers.
    t_state r_state, n_state, r_ret, n_ret;
    logic [3:0] r_op, n_op;
    logic [5:0] r_tin, n_tin, r_pr, n_pr;
    logic [2:0] r_code, n_code;
    logic [31:0] r_set, n_set;
    logic [IW-1:0] r_t, n_t, r_ch, n_ch, r_best, n_best;
    t_task r_rec, n_rec;
    t_lvl r_lrec, n_lrec;
    t_status r_st, n_st;
    logic r_was, n_was;
    logic [IX-1:0] r_i, n_i, r_pidx, n_pidx;
    logic r_pv, n_pv, r_bfound, n_bfound;
    logic [PW-1:0] r_bp, n_bp;
    logic [TASK_COUNT-1:0] r_ready, n_ready, r_blocked, n_blocked, r_present, n_present;
    logic [LEVEL_COUNT-1:0] r_level, n_level;
    logic [IW-1:0] r_run, n_run, r_sel, n_sel;
    logic [PW-1:0] r_run_p, n_run_p;
    logic r_pend, n_pend, r_ken, r_sst;
    logic r_ovld, n_ovld;
    t_status r_o_status, n_o_status;
    logic [4:0] r_o_task, n_o_task, r_o_prio, n_o_prio;
    logic [2:0] r_o_wake, n_o_wake;
    logic r_o_pend, n_o_pend;

    // Shared conditions.
    logic w_tin_ok, w_pr_ok, w_tpres, w_sel_ok, w_run_ok, w_tready;
    logic [IX-1:0] w_tinx, w_ti;
    logic [PW-1:0] w_p;
    t_lvl w_lrec;
    logic [TASK_COUNT-1:0] w_smask;
    logic w_take, w_found_n;
    logic [IW-1:0] w_best_n;
    logic [PW-1:0] w_bp_n;
    logic w_out_free;

    assign w_tin_ok = ({1'b0, r_tin} < 7'(TASK_COUNT));
    assign w_pr_ok = ({1'b0, r_pr} < 7'(LEVEL_COUNT));
    assign w_tinx = r_tin[IX-1:0];
    assign w_tpres = w_tin_ok && r_present[w_tinx];
    assign w_sel_ok = !r_sel[IW-1] && r_present[r_sel[IX-1:0]];
    assign w_run_ok = !r_run[IW-1] && r_present[r_run[IX-1:0]];
    assign w_ti = r_t[IX-1:0];
    assign w_p = r_rec.prio;
    assign w_tready = r_ready[w_ti];
    assign w_lrec = r_lqv ? r_lq : '{head: NIL, tail: NIL};
    assign w_out_free = !r_ovld || !i_stall;

    always_comb begin
        for (int k = 0; k < TASK_COUNT; k++) begin
            w_smask[k] = (k < 32) ? r_set[k % 32] : 1'b0;
        end
    end

    // Running best-of-set compare; ties keep the lower id.
    assign w_take = r_pv && (!r_bfound || (r_tq.prio < r_bp));
    assign w_found_n = r_bfound || r_pv;
    assign w_best_n = w_take ? {1'b0, r_pidx} : r_best;
    assign w_bp_n = w_take ? r_tq.prio : r_bp;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_OUT;
                if (r_ken) begin
                    case (r_op)
                        OP_READY_ADD, OP_READY_REMOVE, OP_UNBLOCK: begin
                            if (w_tpres) n_state = S_LOADT;
                        end
                        OP_SELECT: begin
                            if (r_level != '0) n_state = S_SEL1;
                        end
                        OP_SWITCH: begin
                            if (r_sst && w_sel_ok) n_state = w_run_ok ? S_SW1 : S_SW3;
                        end
                        OP_BLOCK: begin
                            if (r_sst && w_run_ok) n_state = S_LOADT;
                        end
                        OP_WAKE_BEST, OP_FIND_BEST: n_state = S_SCAN;
                        OP_SET_PRIORITY: begin
                            if (w_tin_ok && w_pr_ok && w_tpres) n_state = S_LOADT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_LOADT: begin
                case (r_op)
                    OP_READY_ADD, OP_UNBLOCK: n_state = S_ADD0;
                    OP_READY_REMOVE, OP_BLOCK: n_state = S_REM0;
                    OP_SET_PRIORITY: n_state = w_tready ? S_REM0 : S_PRIO;
                    default: n_state = S_OUT;
                endcase
            end
            S_ADD0: n_state = w_tready ? r_ret : S_ADD1;
            S_ADD1: n_state = w_lrec.tail[IW-1] ? r_ret : S_ADD2;
            S_ADD2: n_state = r_ret;
            S_REM0: n_state = w_tready ? S_REM1 : r_ret;
            S_REM1: n_state = r_rec.prv[IW-1] ? S_REM3 : S_REM2;
            S_REM2: n_state = S_REM3;
            S_REM3: n_state = r_rec.nxt[IW-1] ? S_REM5 : S_REM4;
            S_REM4: n_state = S_REM5;
            S_REM5: n_state = r_ret;
            S_UNBLK, S_BLK, S_SEL1, S_SW5: n_state = S_OUT;
            S_PRIO: n_state = r_was ? S_ADD0 : S_OUT;
            S_SW1: n_state = (r_tq.mode == MODE_RUNNING) ? S_ADD0 : S_SW3;
            S_SW2: n_state = S_SW3;
            S_SW3: n_state = S_SW4;
            S_SW4: n_state = S_REM0;
            S_SCAN: begin
                if (r_i == IX'(TASK_COUNT - 1)) n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                if (!w_found_n || r_op == OP_FIND_BEST) n_state = S_OUT;
                else n_state = S_WAKE;
            end
            S_WAKE: n_state = S_ADD0;
            S_OUT: n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and result.
    always_comb begin
        n_ret = r_ret;
        n_op = r_op;
        n_tin = r_tin;
        n_pr = r_pr;
        n_code = r_code;
        n_set = r_set;
        n_t = r_t;
        n_ch = r_ch;
        n_best = r_best;
        n_rec = r_rec;
        n_lrec = r_lrec;
        n_st = r_st;
        n_was = r_was;
        n_i = r_i;
        n_pidx = r_pidx;
        n_pv = r_pv;
        n_bfound = r_bfound;
        n_bp = r_bp;
        n_ready = r_ready;
        n_blocked = r_blocked;
        n_present = r_present;
        n_level = r_level;
        n_run = r_run;
        n_sel = r_sel;
        n_run_p = r_run_p;
        n_pend = r_pend;
        n_ovld = r_ovld && i_stall;
        n_o_status = r_o_status;
        n_o_task = r_o_task;
        n_o_prio = r_o_prio;
        n_o_wake = r_o_wake;
        n_o_pend = r_o_pend;
        tm_we = 1'b0;
        tm_wa = w_ti;
        tm_wd = r_rec;
        tm_ra = w_ti;
        lm_we = 1'b0;
        lm_wa = w_p;
        lm_wd = r_lrec;
        lm_ra = w_p;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_operation;
                    n_tin = i_task_id;
                    n_pr = i_priority_req;
                    n_code = i_wake_code;
                    n_set = i_task_set;
                    n_st = ST_OK;
                    n_ch = NIL;
                end
            end
            S_DISP: begin
                n_t = {1'b0, w_tinx};
                tm_ra = w_tinx;
                if (!r_ken) begin
                    n_st = ST_STATE;
                end else begin
                    case (r_op)
                        OP_ATTACH: begin
                            if (!w_tin_ok || !w_pr_ok) begin
                                n_st = ST_ARG;
                            end else if (w_tpres) begin
                                n_st = ST_STATE;
                            end else begin
                                tm_we = 1'b1;
                                tm_wa = w_tinx;
                                tm_wd = '{nxt: NIL, prv: NIL, prio: r_pr[PW-1:0],
                                          mode: MODE_READY, wake: 3'd0};
                                n_present[w_tinx] = 1'b1;
                            end
                        end
                        OP_READY_ADD, OP_READY_REMOVE, OP_UNBLOCK: begin
                            if (!w_tpres) n_st = ST_ARG;
                        end
                        OP_SELECT: begin
                            lm_ra = first_one(r_level);
                            if (r_level == '0) n_st = ST_NONE;
                        end
                        OP_SWITCH: begin
                            if (!r_sst || !w_sel_ok) begin
                                n_st = ST_STATE;
                            end else begin
                                n_t = r_run;
                                tm_ra = r_run[IX-1:0];
                            end
                        end
                        OP_BLOCK: begin
                            if (!r_sst || !w_run_ok) begin
                                n_st = ST_STATE;
                            end else begin
                                n_t = r_run;
                                tm_ra = r_run[IX-1:0];
                            end
                        end
                        OP_WAKE_BEST, OP_FIND_BEST: begin
                            n_i = '0;
                            n_pv = 1'b0;
                            n_bfound = 1'b0;
                        end
                        OP_SET_PRIORITY: begin
                            if (!w_tin_ok || !w_pr_ok || !w_tpres) n_st = ST_ARG;
                        end
                        default: n_st = ST_ARG;
                    endcase
                end
            end
            S_LOADT: begin
                n_rec = r_tq;
                n_ret = S_OUT;
                case (r_op)
                    OP_UNBLOCK: begin
                        n_blocked[w_ti] = 1'b0;
                        n_ret = S_UNBLK;
                    end
                    OP_BLOCK: n_ret = S_BLK;
                    OP_SET_PRIORITY: begin
                        n_was = w_tready;
                        n_ret = S_PRIO;
                    end
                    default: n_ret = S_OUT;
                endcase
            end
            // Append the task at the tail of its level list, or only mark the level when it is already ready.
            S_ADD0: begin
                if (w_tready) n_level[w_p] = 1'b1;
            end
            S_ADD1: begin
                n_lrec = w_lrec;
                n_rec.prv = w_lrec.tail;
                n_rec.nxt = NIL;
                tm_we = 1'b1;
                tm_wd = n_rec;
                tm_ra = w_lrec.tail[IX-1:0];
                if (w_lrec.tail[IW-1]) begin
                    lm_we = 1'b1;
                    lm_wd = '{head: r_t, tail: r_t};
                    n_ready[w_ti] = 1'b1;
                    n_level[w_p] = 1'b1;
                end
            end
            S_ADD2: begin
                tm_we = 1'b1;
                tm_wa = r_lrec.tail[IX-1:0];
                tm_wd = r_tq;
                tm_wd.nxt = r_t;
                lm_we = 1'b1;
                lm_wd = '{head: r_lrec.head, tail: r_t};
                n_ready[w_ti] = 1'b1;
                n_level[w_p] = 1'b1;
            end
            // Unlink the task from its level list.
            S_REM1: begin
                n_lrec = w_lrec;
                tm_ra = r_rec.prv[IX-1:0];
                if (r_rec.prv[IW-1]) n_lrec.head = r_rec.nxt;
            end
            S_REM2: begin
                tm_we = 1'b1;
                tm_wa = r_rec.prv[IX-1:0];
                tm_wd = r_tq;
                tm_wd.nxt = r_rec.nxt;
            end
            S_REM3: begin
                tm_ra = r_rec.nxt[IX-1:0];
                if (r_rec.nxt[IW-1]) n_lrec.tail = r_rec.prv;
            end
            S_REM4: begin
                tm_we = 1'b1;
                tm_wa = r_rec.nxt[IX-1:0];
                tm_wd = r_tq;
                tm_wd.prv = r_rec.prv;
            end
            S_REM5: begin
                n_rec.prv = NIL;
                n_rec.nxt = NIL;
                tm_we = 1'b1;
                tm_wd = n_rec;
                lm_we = 1'b1;
                n_ready[w_ti] = 1'b0;
                if (r_lrec.head[IW-1]) n_level[w_p] = 1'b0;
            end
            S_UNBLK: begin
                n_rec.mode = MODE_READY;
                n_rec.wake = r_code;
                tm_we = 1'b1;
                tm_wd = n_rec;
                if (r_rec.prio < r_run_p) n_pend = 1'b1;
            end
            S_BLK: begin
                n_blocked[w_ti] = 1'b1;
                n_rec.mode = MODE_BLOCKED;
                n_rec.wake = 3'd0;
                tm_we = 1'b1;
                tm_wd = n_rec;
                n_pend = 1'b1;
            end
            S_PRIO: begin
                n_rec.prio = r_pr[PW-1:0];
                tm_we = 1'b1;
                tm_wd = n_rec;
                if (r_run == r_t) n_run_p = r_pr[PW-1:0];
                n_ret = S_OUT;
            end
            S_SEL1: begin
                n_sel = w_lrec.head;
                n_ch = w_lrec.head;
            end
            S_SW1: begin
                n_rec = r_tq;
                if (r_tq.mode == MODE_RUNNING) begin
                    n_rec.mode = MODE_READY;
                    n_ret = S_SW2;
                end
            end
            S_SW2: begin
                tm_we = 1'b1;
            end
            S_SW3: begin
                n_t = r_sel;
                tm_ra = r_sel[IX-1:0];
            end
            S_SW4: begin
                n_rec = r_tq;
                n_ret = S_SW5;
            end
            S_SW5: begin
                n_rec.mode = MODE_RUNNING;
                tm_we = 1'b1;
                tm_wd = n_rec;
                n_run = r_t;
                n_run_p = r_rec.prio;
                n_pend = 1'b0;
                n_ch = r_t;
            end
            S_SCAN: begin
                tm_ra = r_i;
                n_pv = w_smask[r_i] && r_present[r_i];
                n_pidx = r_i;
                n_i = r_i + 1'b1;
                n_bfound = w_found_n;
                n_best = w_best_n;
                n_bp = w_bp_n;
            end
            S_SCAN_END: begin
                tm_ra = w_best_n[IX-1:0];
                n_t = w_best_n;
                n_ch = w_best_n;
                if (!w_found_n) n_st = ST_NONE;
            end
            S_WAKE: begin
                n_rec = r_tq;
                n_blocked[w_ti] = 1'b0;
                n_ret = S_UNBLK;
            end
            S_OUT: begin
                tm_ra = r_ch[IX-1:0];
            end
            S_FIN: begin
                // Keep reading the chosen task so its record holds while the output waits.
                tm_ra = r_ch[IX-1:0];
                if (w_out_free) begin
                    n_ovld = 1'b1;
                    n_o_status = r_st;
                    n_o_pend = r_pend;
                    if (r_st == ST_OK && !r_ch[IW-1]) begin
                        n_o_task = 5'(r_ch[IX-1:0]);
                        n_o_prio = 5'(r_tq.prio);
                        n_o_wake = r_tq.wake;
                    end else begin
                        n_o_task = '0;
                        n_o_prio = '0;
                        n_o_wake = '0;
                    end
                end
            end
            default: begin
                n_st = r_st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tm_we) begin
            tm[tm_wa] <= tm_wd;
        end
        r_tq <= tm[tm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            lm[lm_wa] <= lm_wd;
        end
        r_lq <= lm[lm_ra];
        r_lqv <= r_lval[lm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lval <= '0;
            r_ready <= '0;
            r_blocked <= '0;
            r_present <= '0;
            r_level <= '0;
            r_run <= NIL;
            r_run_p <= PW'(LEVEL_COUNT - 1);
            r_sel <= NIL;
            r_pend <= 1'b0;
            r_ken <= 1'b0;
            r_sst <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (lm_we) r_lval[lm_wa] <= 1'b1;
            r_ready <= n_ready;
            r_blocked <= n_blocked;
            r_present <= n_present;
            r_level <= n_level;
            r_run <= n_run;
            r_run_p <= n_run_p;
            r_sel <= n_sel;
            r_pend <= n_pend;
            r_ovld <= n_ovld;
            if (i_cfg_we && i_cfg_index == CFG_KERNEL_EN) r_ken <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_SCHED_START) r_sst <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_op <= n_op;
        r_tin <= n_tin;
        r_pr <= n_pr;
        r_code <= n_code;
        r_set <= n_set;
        r_t <= n_t;
        r_ch <= n_ch;
        r_best <= n_best;
        r_rec <= n_rec;
        r_lrec <= n_lrec;
        r_st <= n_st;
        r_was <= n_was;
        r_i <= n_i;
        r_pidx <= n_pidx;
        r_pv <= n_pv;
        r_bfound <= n_bfound;
        r_bp <= n_bp;
        r_o_status <= n_o_status;
        r_o_task <= n_o_task;
        r_o_prio <= n_o_prio;
        r_o_wake <= n_o_wake;
        r_o_pend <= n_o_pend;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovld;
    assign o_status = r_o_status;
    assign o_chosen_task = r_o_task;
    assign o_chosen_priority = r_o_prio;
    assign o_chosen_wake_code = r_o_wake;
    assign o_schedule_pending = r_o_pend;

endmodule
`default_nettype wire

// ===== tb/tb_priority_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps
module tb_priority_ready_queue_scheduler;
    import prqs_pkg::*;

    localparam int TASKS = 32;
    localparam int LEVELS = 32;
    localparam int NO_TASK = 255;

    // One scheduler command item as it is driven into the block.
    typedef struct {
        t_op         op;
        logic [5:0]  tid;
        logic [5:0]  prio;
        logic [2:0]  wake;
        logic [31:0] tset;
    } sched_cmd_t;

    // One expected scheduler answer.
    typedef struct {
        t_status    status;
        logic [4:0] task_id;
        logic [4:0] prio;
        logic [2:0] wake;
        logic       pending;
    } sched_answer_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        cmd_valid = 1'b0;
    logic [3:0]  cmd_op = '0;
    logic [5:0]  cmd_tid = '0;
    logic [5:0]  cmd_prio = '0;
    logic [2:0]  cmd_wake = '0;
    logic [31:0] cmd_tset = '0;
    logic        ans_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [4:0]  o_chosen_task;
    logic [4:0]  o_chosen_priority;
    logic [2:0]  o_chosen_wake_code;
    logic        o_schedule_pending;

    priority_ready_queue_scheduler i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (cmd_valid),
        .o_stall            (o_stall),
        .i_operation        (cmd_op),
        .i_task_id          (cmd_tid),
        .i_priority_req     (cmd_prio),
        .i_wake_code        (cmd_wake),
        .i_task_set         (cmd_tset),
        .o_valid            (o_valid),
        .i_stall            (ans_stall),
        .o_status           (o_status),
        .o_chosen_task      (o_chosen_task),
        .o_chosen_priority  (o_chosen_priority),
        .o_chosen_wake_code (o_chosen_wake_code),
        .o_schedule_pending (o_schedule_pending),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    // The clock runs with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Commands waiting to be driven, and answers that the block still owes us.
    sched_cmd_t    pending_cmds[$];
    sched_answer_t expected_answers[$];
    int            error_count = 0;
    bit            quiet = 1'b0;

    // Shadow copy of the scheduler state. Task and level links use NO_TASK for an
    // empty pointer, the same way the block treats any id at or above the task count.
    bit         kern_on;
    bit         sched_on;
    bit [31:0]  ready_mask;
    bit [31:0]  level_mask;
    bit [31:0]  blocked_mask;
    bit [31:0]  present_mask;
    int         head_of[LEVELS];
    int         tail_of[LEVELS];
    int         next_of[TASKS];
    int         prev_of[TASKS];
    int         prio_of[TASKS];
    t_mode      mode_of[TASKS];
    logic [2:0] wake_of[TASKS];
    int         run_task;
    int         run_prio;
    int         sel_task;
    int         sel_prio;
    bit         resched;

    function automatic bit task_here(int t);
        return t < TASKS && present_mask[t];
    endfunction

    // Appends a task at the tail of its level, or only marks the level again when
    // the task is already on a ready list.
    task automatic enqueue_ready(int t);
        int p;
        p = prio_of[t];
        if (ready_mask[t]) begin
            level_mask[p] = 1'b1;
            return;
        end
        prev_of[t] = tail_of[p];
        next_of[t] = NO_TASK;
        if (tail_of[p] < TASKS) next_of[tail_of[p]] = t;
        else head_of[p] = t;
        tail_of[p] = t;
        ready_mask[t] = 1'b1;
        level_mask[p] = 1'b1;
    endtask

    task automatic dequeue_ready(int t, int p);
        int pv;
        int nx;
        if (!ready_mask[t]) return;
        pv = prev_of[t];
        nx = next_of[t];
        if (pv < TASKS) next_of[pv] = nx;
        else head_of[p] = nx;
        if (nx < TASKS) prev_of[nx] = pv;
        else tail_of[p] = pv;
        prev_of[t] = NO_TASK;
        next_of[t] = NO_TASK;
        ready_mask[t] = 1'b0;
        if (head_of[p] == NO_TASK) level_mask[p] = 1'b0;
    endtask

    task automatic wake_task(int t, logic [2:0] code);
        blocked_mask[t] = 1'b0;
        enqueue_ready(t);
        mode_of[t] = MODE_READY;
        wake_of[t] = code;
        if (prio_of[t] < run_prio) resched = 1'b1;
    endtask

    task automatic clear_shadow();
        kern_on = 1'b0;
        sched_on = 1'b0;
        ready_mask = '0;
        level_mask = '0;
        blocked_mask = '0;
        present_mask = '0;
        for (int i = 0; i < LEVELS; i++) begin
            head_of[i] = NO_TASK;
            tail_of[i] = NO_TASK;
        end
        for (int i = 0; i < TASKS; i++) begin
            next_of[i] = NO_TASK;
            prev_of[i] = NO_TASK;
            prio_of[i] = 0;
            mode_of[i] = MODE_READY;
            wake_of[i] = '0;
        end
        run_task = NO_TASK;
        run_prio = LEVELS - 1;
        sel_task = NO_TASK;
        sel_prio = 0;
        resched = 1'b0;
    endtask

    // Applies one accepted command to the shadow state and queues the answer it causes.
    task automatic predict_answer(sched_cmd_t c);
        sched_answer_t a;
        t_status st;
        int ch;
        int t;
        int pr;
        int bp;
        bit was;
        st = ST_OK;
        ch = NO_TASK;
        t = c.tid;
        pr = c.prio;
        if (!kern_on) begin
            st = ST_STATE;
        end else begin
            case (c.op)
                OP_ATTACH: begin
                    if (t >= TASKS || pr >= LEVELS) st = ST_ARG;
                    else if (task_here(t)) st = ST_STATE;
                    else begin
                        present_mask[t] = 1'b1;
                        prio_of[t] = pr;
                        mode_of[t] = MODE_READY;
                        wake_of[t] = '0;
                        next_of[t] = NO_TASK;
                        prev_of[t] = NO_TASK;
                    end
                end
                OP_READY_ADD, OP_READY_REMOVE, OP_UNBLOCK: begin
                    if (!task_here(t)) st = ST_ARG;
                    else if (c.op == OP_READY_ADD) enqueue_ready(t);
                    else if (c.op == OP_READY_REMOVE) dequeue_ready(t, prio_of[t]);
                    else wake_task(t, c.wake);
                end
                OP_SELECT: begin
                    st = ST_NONE;
                    for (int i = 0; i < LEVELS; i++) begin
                        if (level_mask[i] && head_of[i] < TASKS) begin
                            sel_task = head_of[i];
                            sel_prio = prio_of[sel_task];
                            ch = sel_task;
                            st = ST_OK;
                            break;
                        end
                    end
                end
                OP_SWITCH: begin
                    if (!sched_on || !task_here(sel_task)) begin
                        st = ST_STATE;
                    end else begin
                        // The outgoing task rejoins the tail of its level.
                        if (task_here(run_task) && mode_of[run_task] == MODE_RUNNING) begin
                            mode_of[run_task] = MODE_READY;
                            enqueue_ready(run_task);
                        end
                        dequeue_ready(sel_task, prio_of[sel_task]);
                        mode_of[sel_task] = MODE_RUNNING;
                        run_task = sel_task;
                        run_prio = prio_of[sel_task];
                        resched = 1'b0;
                        ch = sel_task;
                    end
                end
                OP_BLOCK: begin
                    if (!sched_on || !task_here(run_task)) begin
                        st = ST_STATE;
                    end else begin
                        dequeue_ready(run_task, prio_of[run_task]);
                        blocked_mask[run_task] = 1'b1;
                        mode_of[run_task] = MODE_BLOCKED;
                        wake_of[run_task] = '0;
                        resched = 1'b1;
                    end
                end
                OP_WAKE_BEST, OP_FIND_BEST: begin
                    // Strictly lower priority wins, so ties keep the lowest id.
                    bp = 1 << 16;
                    for (int i = 0; i < TASKS; i++) begin
                        if (c.tset[i] && present_mask[i] && prio_of[i] < bp) begin
                            bp = prio_of[i];
                            ch = i;
                        end
                    end
                    if (ch == NO_TASK) st = ST_NONE;
                    else if (c.op == OP_WAKE_BEST) wake_task(ch, c.wake);
                end
                OP_SET_PRIORITY: begin
                    if (t >= TASKS || pr >= LEVELS || !task_here(t)) begin
                        st = ST_ARG;
                    end else begin
                        was = ready_mask[t];
                        if (was) dequeue_ready(t, prio_of[t]);
                        prio_of[t] = pr;
                        if (run_task == t) run_prio = pr;
                        if (sel_task == t) sel_prio = pr;
                        if (was) enqueue_ready(t);
                    end
                end
                default: st = ST_ARG;
            endcase
        end
        a.status = st;
        a.pending = resched;
        if (st == ST_OK && ch < TASKS) begin
            a.task_id = ch[4:0];
            a.prio = prio_of[ch][4:0];
            a.wake = wake_of[ch];
        end else begin
            a.task_id = '0;
            a.prio = '0;
            a.wake = '0;
        end
        expected_answers.push_back(a);
    endtask

    // Command driver. A held item stays on the ports until the block takes it; gaps
    // come in bursts and are chosen only while no item is held.
    int         send_gap = 0;
    sched_cmd_t held_cmd;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_valid && !o_stall) predict_answer(held_cmd);
            if (!cmd_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    cmd_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 11) == 0) begin
                    send_gap <= $urandom_range(0, 9);
                    cmd_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    held_cmd = pending_cmds.pop_front();
                    cmd_op <= held_cmd.op;
                    cmd_tid <= held_cmd.tid;
                    cmd_prio <= held_cmd.prio;
                    cmd_wake <= held_cmd.wake;
                    cmd_tset <= held_cmd.tset;
                    cmd_valid <= 1'b1;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Answer monitor. Each answer taken is checked against the oldest expectation,
    // and the stall toward the block is raised in random bursts.
    int  recv_gap = 0;
    sched_answer_t want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !ans_stall) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: answer with none expected: status %0d task %0d",
                             $time, o_status, o_chosen_task);
                    error_count++;
                end else begin
                    want = expected_answers.pop_front();
                    if (o_status !== want.status || o_chosen_task !== want.task_id ||
                        o_chosen_priority !== want.prio ||
                        o_chosen_wake_code !== want.wake ||
                        o_schedule_pending !== want.pending) begin
                        $display("%0t: expected st %0d task %0d prio %0d wake %0d pend %0d",
                                 $time, want.status, want.task_id, want.prio,
                                 want.wake, want.pending);
                        $display("%0t: actual   st %0d task %0d prio %0d wake %0d pend %0d",
                                 $time, o_status, o_chosen_task, o_chosen_priority,
                                 o_chosen_wake_code, o_schedule_pending);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                ans_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                recv_gap <= $urandom_range(0, 9);
                ans_stall <= 1'b1;
            end else begin
                ans_stall <= 1'b0;
            end
        end
    end

    task automatic queue_cmd(t_op op, int t, int p, int w, logic [31:0] s);
        sched_cmd_t c;
        c.op = op;
        c.tid = t[5:0];
        c.prio = p[5:0];
        c.wake = w[2:0];
        c.tset = s;
        pending_cmds.push_back(c);
    endtask

    // Blocks until every queued item has been taken and every answer has come back.
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || cmd_valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KERNEL_EN) kern_on = val;
        else sched_on = val;
        @(posedge i_clk);
    endtask

    // Random command mix. Ids mostly hit real tasks, with some beyond the task count;
    // a select is often followed by a switch so the running task keeps changing.
    task automatic queue_random(int count);
        int r;
        int t;
        int p;
        logic [31:0] s;
        for (int n = 0; n < count; n++) begin
            t = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 31);
            p = ($urandom_range(0, 11) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 31);
            case ($urandom_range(0, 3))
                0: s = $urandom;
                1: s = 32'd1 << $urandom_range(0, 31);
                2: s = $urandom & $urandom & $urandom;
                default: s = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd0;
            endcase
            r = $urandom_range(0, 99);
            if (r < 3) queue_cmd(t_op'($urandom_range(10, 15)), t, p, $urandom, s);
            else if (r < 15) begin
                queue_cmd(OP_SELECT, t, p, 0, s);
                queue_cmd(OP_SWITCH, t, p, 0, s);
                n++;
            end else queue_cmd(t_op'($urandom_range(0, 9)), t, p, $urandom, s);
        end
    endtask

    initial begin
        clear_shadow();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the kernel off every command is refused.
        queue_cmd(OP_ATTACH, 0, 0, 0, 32'd0);
        queue_cmd(OP_SELECT, 63, 63, 7, 32'hFFFF_FFFF);
        wait_idle();

        // Kernel on, scheduler stopped: attach errors, and switch and block refused.
        write_reg(CFG_KERNEL_EN, 1'b1);
        queue_cmd(OP_ATTACH, 0, 31, 0, 32'd0);
        queue_cmd(OP_ATTACH, 31, 0, 0, 32'd0);
        queue_cmd(OP_ATTACH, 40, 3, 0, 32'd0);
        queue_cmd(OP_ATTACH, 1, 40, 0, 32'd0);
        queue_cmd(OP_ATTACH, 0, 5, 0, 32'd0);
        queue_cmd(OP_SWITCH, 0, 0, 0, 32'd0);
        queue_cmd(OP_BLOCK, 0, 0, 0, 32'd0);
        wait_idle();

        // Scheduler running: every operation and its corner cases.
        write_reg(CFG_SCHED_START, 1'b1);
        queue_cmd(OP_READY_ADD, 0, 0, 0, 32'd0);
        queue_cmd(OP_READY_ADD, 31, 0, 0, 32'd0);
        queue_cmd(OP_READY_ADD, 31, 0, 0, 32'd0);
        queue_cmd(OP_READY_REMOVE, 1, 0, 0, 32'd0);
        queue_cmd(OP_SELECT, 0, 0, 0, 32'd0);
        queue_cmd(OP_SWITCH, 0, 0, 0, 32'd0);
        queue_cmd(OP_BLOCK, 0, 0, 0, 32'd0);
        queue_cmd(OP_UNBLOCK, 31, 0, 7, 32'd0);
        queue_cmd(OP_FIND_BEST, 0, 0, 0, 32'hFFFF_FFFF);
        queue_cmd(OP_WAKE_BEST, 0, 0, 5, 32'd0);
        queue_cmd(OP_WAKE_BEST, 0, 0, 3, 32'h8000_0001);
        queue_cmd(OP_SET_PRIORITY, 0, 0, 0, 32'd0);
        queue_cmd(OP_SET_PRIORITY, 31, 63, 0, 32'd0);
        queue_cmd(OP_SET_PRIORITY, 63, 1, 0, 32'd0);
        queue_cmd(t_op'(4'd10), 0, 0, 0, 32'd0);
        queue_cmd(t_op'(4'd15), 63, 63, 7, 32'hFFFF_FFFF);
        queue_cmd(OP_READY_REMOVE, 0, 0, 0, 32'd0);
        queue_cmd(OP_READY_REMOVE, 31, 0, 0, 32'd0);
        queue_cmd(OP_SELECT, 0, 0, 0, 32'd0);
        // Hold the sender until the block has answered everything so far.
        wait_idle();

        queue_random(450);
        wait_idle();
        write_reg(CFG_SCHED_START, 1'b0);
        queue_random(100);
        wait_idle();
        write_reg(CFG_SCHED_START, 1'b1);
        queue_random(400);
        wait_idle();

        // Last stretch runs with no idling on either side.
        quiet = 1'b1;
        queue_random(150);
        wait_idle();
        write_reg(CFG_KERNEL_EN, 1'b0);
        queue_random(10);
        wait_idle();

        repeat (50) @(posedge i_clk);
        if (error_count == 0) $display("tb_priority_ready_queue_scheduler OK");
        else $display("tb_priority_ready_queue_scheduler NOT OK");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_priority_ready_queue_scheduler NOT OK");
        $finish;
    end

endmodule
